### hw/rtl/lkv_pkg.sv
// Shared constants for the LRU key-value cache.
`timescale 1ns / 1ps
package lkv_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

endpackage

### hw/rtl/lkv_req_reg.sv
// Input register stage of the LRU key-value cache.
`timescale 1ns / 1ps
module lkv_req_reg #(
   parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic signed [KEY_BITS-1:0]   req_key,
   input  logic signed [VALUE_BITS-1:0] req_write_value,
   input  logic                         fire,
   output logic                         s1_valid,
   output logic                         s1_op,
   output logic [KEY_BITS-1:0]          s1_key,
   output logic [VALUE_BITS-1:0]        s1_value
);

   logic                  valid_ff, valid_in;
   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  take;

   assign req_stall = valid_ff & ~fire;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff    <= req_op;
         key_ff   <= req_key;
         value_ff <= req_write_value;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_op    = op_ff;
   assign s1_key   = key_ff;
   assign s1_value = value_ff;

endmodule

### hw/rtl/lkv_store.sv
// Entry store: parallel key match, recency ranks and replacement.
`timescale 1ns / 1ps
module lkv_store #(
   parameter int ENTRIES    = lkv_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lkv_pkg::CAP_BITS-1:0]  capacity,
   input  logic                          fire,
   input  logic                          op,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [VALUE_BITS-1:0]         value,
   output logic                          hit,
   output logic [VALUE_BITS-1:0]         read_value
);

   localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_BITS  = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (OCC_BITS > lkv_pkg::CAP_BITS) ? OCC_BITS : lkv_pkg::CAP_BITS;

   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [RANK_BITS-1:0]  rank_ff  [ENTRIES];

   logic [ENTRIES-1:0]    match, lru, free_vec, first_free, target;
   logic [VALUE_BITS-1:0] hit_value;
   logic [RANK_BITS-1:0]  hit_rank, lru_rank;
   logic [OCC_BITS-1:0]   old_rank;
   logic [CMP_BITS-1:0]   cap_eff, occ_ext;
   logic                  full, is_put, do_update, do_insert, write_key;

   assign is_put  = (op == lkv_pkg::OP_PUT);
   assign occ_ext = CMP_BITS'(occ_ff);

   // clamp capacity into 1..ENTRIES
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CMP_BITS'(1);
      end else if (CMP_BITS'(capacity) > CMP_BITS'(ENTRIES)) begin
         cap_eff = CMP_BITS'(ENTRIES);
      end else begin
         cap_eff = CMP_BITS'(capacity);
      end
   end

   assign full     = (occ_ext >= cap_eff);
   assign lru_rank = RANK_BITS'(occ_ff - OCC_BITS'(1));

   always_comb begin
      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] & (key_ff[i] == key);
         lru[i]   = valid_ff[i] & (rank_ff[i] == lru_rank);
         if (match[i]) begin
            hit_value = hit_value | value_ff[i];
            hit_rank  = hit_rank  | rank_ff[i];
         end
      end
   end

   assign hit = |match;

   // lowest free slot
   assign free_vec   = ~valid_ff;
   assign first_free = free_vec & (~free_vec + ENTRIES'(1));

   always_comb begin
      read_value = '0;
      if (!is_put) begin
         read_value = hit ? hit_value : '1;
      end
   end

   // target slot and the rank it leaves: ranks below it age by one
   always_comb begin
      do_update = 1'b0;
      do_insert = 1'b0;
      write_key = 1'b0;
      target    = '0;
      old_rank  = '0;
      if (hit) begin
         do_update = 1'b1;
         target    = match;
         old_rank  = OCC_BITS'(hit_rank);
      end else if (is_put && full) begin
         do_update = 1'b1;
         write_key = 1'b1;
         target    = lru;
         old_rank  = OCC_BITS'(lru_rank);
      end else if (is_put) begin
         do_update = 1'b1;
         do_insert = 1'b1;
         write_key = 1'b1;
         target    = first_free;
         old_rank  = occ_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (fire && do_insert) begin
         valid_in = valid_ff | first_free;
         occ_in   = occ_ff + OCC_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && do_update) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (target[i]) begin
               rank_ff[i] <= '0;
               if (write_key) begin
                  key_ff[i] <= key;
               end
               if (is_put) begin
                  value_ff[i] <= value;
               end
            end else if (valid_ff[i] && (OCC_BITS'(rank_ff[i]) < old_rank)) begin
               rank_ff[i] <= rank_ff[i] + RANK_BITS'(1);
            end
         end
      end
   end

endmodule

### hw/rtl/lkv_rsp_reg.sv
// Result register stage of the LRU key-value cache.
`timescale 1ns / 1ps
module lkv_rsp_reg #(
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         s1_valid,
   input  logic                         hit,
   input  logic [VALUE_BITS-1:0]        read_value,
   output logic                         fire,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [VALUE_BITS-1:0] rsp_read_value
);

   logic                  valid_ff, valid_in;
   logic                  hit_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // a transaction moves on when the result slot is empty or draining
   assign fire     = s1_valid & (~valid_ff | ~rsp_stall);
   assign valid_in = fire | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         hit_ff   <= hit;
         value_ff <= read_value;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_read_value = value_ff;

endmodule

### hw/rtl/lru_key_value_cache.sv
// LRU key-value cache, top level.
// A request is held in the input register, then the result register, before result valid.
// Throughput: one get or put per cycle while rsp_stall is low; key match is combinational.
// Reset (synchronous): all entries invalid, occupancy zero, capacity 16.
// Capacity is taken through csr_valid/csr_ready, always ready.
`timescale 1ns / 1ps
module lru_key_value_cache #(
   parameter int ENTRIES    = lkv_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic signed [KEY_BITS-1:0]     req_key,
   input  logic signed [VALUE_BITS-1:0]   req_write_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic signed [VALUE_BITS-1:0]   rsp_read_value,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lkv_pkg::CAP_BITS-1:0]   csr_capacity
);

   logic [lkv_pkg::CAP_BITS-1:0] capacity_ff, capacity_in;
   logic                         fire, s1_valid, s1_op, hit;
   logic [KEY_BITS-1:0]          s1_key;
   logic [VALUE_BITS-1:0]        s1_value, read_value;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_capacity : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkv_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lkv_req_reg #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_req (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .fire            (fire),
      .s1_valid        (s1_valid),
      .s1_op           (s1_op),
      .s1_key          (s1_key),
      .s1_value        (s1_value)
   );

   lkv_store #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .fire       (fire),
      .op         (s1_op),
      .key        (s1_key),
      .value      (s1_value),
      .hit        (hit),
      .read_value (read_value)
   );

   lkv_rsp_reg #(
      .VALUE_BITS (VALUE_BITS)
   ) u_rsp (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .hit            (hit),
      .read_value     (read_value),
      .fire           (fire),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value)
   );

endmodule
